@@ design/mhpq_pkg.sv @@
// Shared types, constants and the key compare for the min-heap priority queue.
// No dependencies; every design file but mhpq_ram depends on this package.
`timescale 1ns / 1ps

package mhpq_pkg;

    // Fixed field widths of the request and response items.
    localparam int KEY_W    = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    typedef logic signed [KEY_W-1:0] key_t;

    // Operation codes carried by a request item.
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_PEEK = 2'd2
    } kind_t;

    // Status codes carried by a response item.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_ROOT,
        S_DOWN,
        S_PLACE,
        S_FINISH
    } state_t;

    // Finished response handed from the sequencer to the output stage.
    typedef struct packed {
        key_t                key;
        status_t             status;
        logic [COUNT_W-1:0]  count;
    } result_t;

    // Signed key compare shared by the sift-up and sift-down steps.
    function automatic logic key_less(input key_t a, input key_t b);
        return a < b;
    endfunction

endpackage

@@ design/mhpq_if.sv @@
// Valid/ready channel interfaces for heap requests and heap responses.
// Depends on mhpq_pkg for the field widths.
`timescale 1ns / 1ps

interface heap_req_if;
    logic                               valid;
    logic                               ready;
    logic [mhpq_pkg::KIND_W-1:0]        kind;
    logic signed [mhpq_pkg::KEY_W-1:0]  key_in;

    modport source (output valid, output kind, output key_in, input ready);
    modport sink   (input valid, input kind, input key_in, output ready);
endinterface

interface heap_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [mhpq_pkg::KEY_W-1:0]  key_out;
    logic [mhpq_pkg::STATUS_W-1:0]      status;
    logic [mhpq_pkg::COUNT_W-1:0]       count;

    modport source (output valid, output key_out, output status, output count, input ready);
    modport sink   (input valid, input key_out, input status, input count, output ready);
endinterface

@@ design/mhpq_ram.sv @@
// Generic RAM: one write port and two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ design/mhpq_seq.sv @@
// Heap sequencer: accepts requests and walks the sift-up and sift-down loops
// one level per cycle over the key RAM. Depends on mhpq_pkg and heap_req_if.
`timescale 1ns / 1ps

module mhpq_seq #(
    parameter int CAPACITY = 256,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    heap_req_if.sink                req,
    output logic                    ram_we,
    output logic [AW-1:0]           ram_waddr,
    output logic [mhpq_pkg::KEY_W-1:0] ram_wdata,
    output logic [AW-1:0]           ram_raddr_a,
    input  logic [mhpq_pkg::KEY_W-1:0] ram_rdata_a,
    output logic [AW-1:0]           ram_raddr_b,
    input  logic [mhpq_pkg::KEY_W-1:0] ram_rdata_b,
    output logic                    res_valid,
    input  logic                    res_ready,
    output mhpq_pkg::result_t       res
);

    import mhpq_pkg::*;

    // Index width that holds the left child index of any entry.
    localparam int IW = AW + 1;

    state_t          state_reg, state_next;
    kind_t           kind_reg, kind_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [AW-1:0]   pos_reg, pos_next;
    key_t            hold_reg, hold_next;
    key_t            res_key_reg, res_key_next;
    status_t         res_status_reg, res_status_next;

    logic            accept;
    kind_t           in_kind;
    logic            full;
    logic            empty;
    key_t            rd_a;
    key_t            rd_b;
    logic [AW-1:0]   fill_pos;
    logic [AW-1:0]   fill_pos_m1;
    logic [AW-1:0]   fill_parent;
    logic [AW-1:0]   parent;
    logic [AW-1:0]   grand;
    logic [IW-1:0]   fill_w;
    logic [IW-1:0]   left_w;
    logic [IW-1:0]   right_w;
    logic            right_ok;
    logic            pick_right;
    key_t            pick_val;
    logic [IW-1:0]   pick_w;
    logic [AW-1:0]   pick_pos;
    logic [IW-1:0]   nleft_w;
    logic [IW-1:0]   nright_w;
    logic            up_move;
    logic            down_move;
    logic [CW-1:0]   fill_dec;

    // Handshake and request decode.
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign in_kind   = kind_t'(req.kind);
    assign full      = (fill_reg == CW'(CAPACITY));
    assign empty     = (fill_reg == '0);
    assign rd_a      = key_t'(ram_rdata_a);
    assign rd_b      = key_t'(ram_rdata_b);
    assign fill_dec  = fill_reg - CW'(1);

    // Index arithmetic for the parent and child positions.
    assign fill_pos    = fill_reg[AW-1:0];
    assign fill_pos_m1 = fill_pos - AW'(1);
    assign fill_parent = fill_pos_m1 >> 1;
    assign parent      = (pos_reg - AW'(1)) >> 1;
    assign grand       = (parent - AW'(1)) >> 1;
    assign fill_w      = IW'(fill_reg);
    assign left_w      = {pos_reg, 1'b1};
    assign right_w     = left_w + IW'(1);

    // Shared compare unit: child select and move decisions.
    assign right_ok   = right_w < fill_w;
    assign pick_right = right_ok && key_less(rd_b, rd_a);
    assign pick_val   = pick_right ? rd_b : rd_a;
    assign pick_w     = pick_right ? right_w : left_w;
    assign pick_pos   = pick_w[AW-1:0];
    assign nleft_w    = {pick_pos, 1'b1};
    assign nright_w   = nleft_w + IW'(1);
    assign up_move    = key_less(hold_reg, rd_a);
    assign down_move  = key_less(pick_val, hold_reg);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_kind)
                        KIND_PUSH:
                        begin
                            if (full)
                            begin
                                state_next = S_FINISH;
                            end
                            else if (empty)
                            begin
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                state_next = S_UP;
                            end
                        end
                        KIND_POP, KIND_PEEK:
                        begin
                            state_next = empty ? S_FINISH : S_ROOT;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                state_next = (up_move && (parent != '0)) ? S_UP : S_PLACE;
            end
            S_ROOT:
            begin
                if (kind_reg == KIND_PEEK)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = (IW'(1) < IW'(fill_dec)) ? S_DOWN : S_PLACE;
                end
            end
            S_DOWN:
            begin
                state_next = (down_move && (nleft_w < fill_w)) ? S_DOWN : S_PLACE;
            end
            S_PLACE:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = res_ready ? S_IDLE : S_FINISH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, RAM port control and register updates.
    always_comb
    begin
        kind_next       = kind_reg;
        fill_next       = fill_reg;
        pos_next        = pos_reg;
        hold_next       = hold_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = hold_reg;
        ram_raddr_a     = '0;
        ram_raddr_b     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                // Prefetch the parent of the new slot, or the root and the last entry.
                ram_raddr_a = (in_kind == KIND_PUSH) ? fill_parent : '0;
                ram_raddr_b = fill_pos_m1;
                if (accept)
                begin
                    kind_next       = in_kind;
                    res_key_next    = '0;
                    res_status_next = ST_OK;
                    unique case (in_kind)
                        KIND_PUSH:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                hold_next = key_t'(req.key_in);
                                pos_next  = fill_pos;
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        KIND_POP, KIND_PEEK:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // Move the parent down into the hole and fetch the next parent.
                ram_raddr_a = grand;
                if (up_move)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = rd_a;
                    pos_next  = parent;
                end
            end
            S_ROOT:
            begin
                // Root is the result; a pop lifts the last entry into the root hole.
                ram_raddr_a  = AW'(1);
                ram_raddr_b  = AW'(2);
                res_key_next = rd_a;
                if (kind_reg == KIND_POP)
                begin
                    fill_next = fill_dec;
                    hold_next = rd_b;
                    pos_next  = '0;
                end
            end
            S_DOWN:
            begin
                // Move the smaller child up into the hole and fetch its children.
                ram_raddr_a = nleft_w[AW-1:0];
                ram_raddr_b = nright_w[AW-1:0];
                if (down_move)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = pick_val;
                    pos_next  = pick_pos;
                end
            end
            S_PLACE:
            begin
                ram_we = 1'b1;
            end
            S_FINISH:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Result handed to the output stage.
    assign res_valid  = (state_reg == S_FINISH);
    assign res.key    = res_key_reg;
    assign res.status = res_status_reg;
    assign res.count  = COUNT_W'(fill_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_PUSH;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            fill_reg  <= fill_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        hold_reg       <= hold_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
    end

`ifndef NO_ASSERTIONS
    // The key count never passes the capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("heap count exceeds capacity");

    // A sift-up step always has a parent to compare with.
    a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP) |-> (pos_reg != '0))
        else $error("sift-up step at the root");

    // A sift-down step only compares against an existing left child.
    a_down_child: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOWN) |-> (left_w < fill_w))
        else $error("sift-down step without a child");

    // The count changes only when an item is taken or a pop removes the root.
    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != S_ROOT) && !accept) |=> $stable(fill_reg))
        else $error("heap count changed outside an update");
`endif

endmodule

@@ design/mhpq_out.sv @@
// Output register stage for heap responses; frees the sequencer while the
// receiver stalls. Depends on mhpq_pkg and heap_rsp_if.
`timescale 1ns / 1ps

module mhpq_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    output logic              res_ready,
    input  mhpq_pkg::result_t res,
    heap_rsp_if.source        rsp
);

    import mhpq_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;
    logic    load;

    // The register takes a new item when empty or when its item leaves.
    assign res_ready = !valid_reg || rsp.ready;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (load)
        begin
            data_next  = res;
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Response channel.
    assign rsp.valid   = valid_reg;
    assign rsp.key_out = data_reg.key;
    assign rsp.status  = data_reg.status;
    assign rsp.count   = data_reg.count;

endmodule

@@ design/min_heap_priority_queue.sv @@
// Binary min-heap priority queue of signed 32-bit keys.
// Request channel req: kind (push, pop, peek) and key_in; one response per
// request on channel rsp: key_out, status (ok, empty, full) and count.
// Requests are taken one at a time: ready is high only while the sequencer
// is idle. The sequencer moves the sifted key one heap level per cycle; each
// step compares registered RAM read data and writes at most one entry.
// A pop or peek on an empty heap, a push into a full heap or an unused kind
// takes no heap step, and a peek reads only the root. A push sifts its key up
// and a pop sifts the last key down, each by the number of levels the key
// moves (at most 8 on a push and 7 on a pop for 256 entries), so the sift
// depth sets how long the operation takes.
// The response leaves through an output register, so a stalled receiver
// holds only that register; the sequencer then waits with its next result
// until the register frees.
// Reset empties the heap at once (count zero); the key RAM is not cleared.
// Depends on mhpq_pkg, heap_req_if, heap_rsp_if, mhpq_ram, mhpq_seq and mhpq_out.
`timescale 1ns / 1ps

module min_heap_priority_queue #(
    parameter int CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    heap_req_if.sink    req,
    heap_rsp_if.source  rsp
);

    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr_a;
    logic [KEY_W-1:0] ram_rdata_a;
    logic [AW-1:0]    ram_raddr_b;
    logic [KEY_W-1:0] ram_rdata_b;
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    // Key storage.
    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    // Operation sequencer and compare unit.
    mhpq_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_rdata_a (ram_rdata_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_b (ram_rdata_b),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Response register.
    mhpq_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rsp       (rsp)
    );

endmodule

@@ verif/tb_min_heap_priority_queue.sv @@
// Self-checking bench for the min-heap priority queue: a directed table, then
// mixed, fill, drain and mixed phases, checked against a heap kept in the bench.
// Depends on mhpq_pkg, heap_req_if, heap_rsp_if and min_heap_priority_queue.
`timescale 1ns / 1ps

module tb_min_heap_priority_queue;

    import mhpq_pkg::*;

    localparam int          HEAP_CAP     = 256;
    localparam int          IDLE_LIMIT   = 4000;
    localparam int          RX_HOLD_LEN  = 300;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [1:0]  KIND_UNUSED  = 2'd3;
    localparam key_t        KEY_MAX      = 32'sh7fffffff;
    localparam key_t        KEY_MIN      = 32'sh80000000;

    // One stimulus row; typed rows carry the expected result written out.
    typedef struct packed {
        logic [1:0]         kind;
        key_t               key;
        logic               typed;
        key_t               ekey;
        logic [1:0]         estatus;
        logic [COUNT_W-1:0] ecount;
    } op_row_t;

    localparam int N_DIRECTED = 25;

    logic clk;
    logic rst_n;

    heap_req_if req();
    heap_rsp_if rsp();

    min_heap_priority_queue #(
        .CAPACITY(HEAP_CAP)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    // Bench copy of the heap and the results still owed by the block.
    key_t        heap_keys [HEAP_CAP];
    int unsigned heap_fill;
    result_t     due_results [$];
    int          mismatch_count;
    logic        rx_hold;
    logic        steady;
    int          idle_cycles;

    op_row_t directed_ops [N_DIRECTED] = '{
        '{KIND_POP,    32'sd0,  1'b1, 32'sd0,  ST_EMPTY, 9'd0},
        '{KIND_PEEK,   32'sd0,  1'b1, 32'sd0,  ST_EMPTY, 9'd0},
        '{KIND_PUSH,   KEY_MAX, 1'b1, 32'sd0,  ST_OK,    9'd1},
        '{KIND_PEEK,   32'sd0,  1'b1, KEY_MAX, ST_OK,    9'd1},
        '{KIND_PUSH,   KEY_MIN, 1'b1, 32'sd0,  ST_OK,    9'd2},
        '{KIND_PEEK,   32'sd0,  1'b1, KEY_MIN, ST_OK,    9'd2},
        '{KIND_UNUSED, 32'sd5,  1'b1, 32'sd0,  ST_OK,    9'd2},
        '{KIND_PUSH,   -32'sd1, 1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_PUSH,   32'sd0,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_PUSH,   32'sd1,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_PUSH,   -32'sd1, 1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_PUSH,   32'sd5,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_PUSH,   32'sd5,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_PUSH,   32'sd3,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_POP,    32'sd0,  1'b1, KEY_MIN, ST_OK,    9'd8},
        '{KIND_POP,    32'sd0,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_POP,    32'sd0,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_PEEK,   32'sd0,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_POP,    32'sd0,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_POP,    32'sd0,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_POP,    32'sd0,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_POP,    32'sd0,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_POP,    32'sd0,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_POP,    32'sd0,  1'b0, 32'sd0,  ST_OK,    9'd0},
        '{KIND_POP,    32'sd0,  1'b1, 32'sd0,  ST_EMPTY, 9'd0}
    };

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Apply one operation to the bench heap and return the result it gives.
    function automatic result_t apply_heap_op(input logic [1:0] kind, input key_t key);
        result_t     r;
        int unsigned pos;
        int unsigned up;
        int unsigned left;
        int unsigned pick;
        key_t        tmp;
        logic        settled;
        r.key    = '0;
        r.status = ST_OK;
        if (kind == KIND_PUSH)
        begin
            if (heap_fill >= HEAP_CAP)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // Sift up while strictly smaller than the parent.
                pos = heap_fill;
                heap_keys[pos] = key;
                heap_fill++;
                while (pos != 0)
                begin
                    up = (pos - 1) / 2;
                    if (!(heap_keys[pos] < heap_keys[up]))
                        break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[up];
                    heap_keys[up] = tmp;
                    pos = up;
                end
            end
        end
        else if (kind == KIND_POP || kind == KIND_PEEK)
        begin
            if (heap_fill == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.key = heap_keys[0];
                if (kind == KIND_POP)
                begin
                    // Move the last key to the root and sift it down; left wins ties.
                    heap_keys[0] = heap_keys[heap_fill - 1];
                    heap_fill--;
                    pos = 0;
                    settled = 1'b0;
                    while (!settled)
                    begin
                        left = 2 * pos + 1;
                        if (left >= heap_fill)
                        begin
                            settled = 1'b1;
                        end
                        else
                        begin
                            pick = left;
                            if (left + 1 < heap_fill && heap_keys[left + 1] < heap_keys[left])
                                pick = left + 1;
                            if (!(heap_keys[pick] < heap_keys[pos]))
                            begin
                                settled = 1'b1;
                            end
                            else
                            begin
                                tmp = heap_keys[pick];
                                heap_keys[pick] = heap_keys[pos];
                                heap_keys[pos] = tmp;
                                pos = pick;
                            end
                        end
                    end
                end
            end
        end
        r.count = heap_fill[COUNT_W-1:0];
        return r;
    endfunction

    // Gap length: none while steady is set, else mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Keys: extremes, a narrow band that makes ties, and full-range values.
    function automatic key_t rand_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return KEY_MAX;
        if (r == 1)
            return KEY_MIN;
        if (r < 5)
            return key_t'($urandom_range(0, 16)) - 32'sd8;
        return key_t'($urandom);
    endfunction

    // A random operation with the given share of pushes, in percent.
    function automatic op_row_t mixed_op(input int push_pct);
        op_row_t row;
        int      r;
        row = '0;
        row.key = rand_key();
        r = $urandom_range(0, 99);
        if (r < push_pct)
            row.kind = KIND_PUSH;
        else if (r < push_pct + (97 - push_pct) * 2 / 3)
            row.kind = KIND_POP;
        else if (r < 97)
            row.kind = KIND_PEEK;
        else
            row.kind = KIND_UNUSED;
        return row;
    endfunction

    function automatic op_row_t plain_op(input logic [1:0] kind, input key_t key);
        op_row_t row;
        row = '0;
        row.kind = kind;
        row.key = key;
        return row;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d, at %0t", field, got, want, $time);
        mismatch_count++;
    endtask

    // Offer one item and wait until it is accepted; valid stays high afterward.
    task automatic send_op(input op_row_t row);
        result_t r;
        req.valid  <= 1'b1;
        req.kind   <= row.kind;
        req.key_in <= row.key;
        do
            @(posedge clk);
        while (!req.ready);
        r = apply_heap_op(row.kind, row.key);
        if (row.typed)
        begin
            r.key    = row.ekey;
            r.status = status_t'(row.estatus);
            r.count  = row.ecount;
        end
        due_results.push_back(r);
    endtask

    // Idle the request side for a random gap after an accepted item.
    task automatic tx_pause();
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Response side: random ready pattern, plus one long hold on request.
    initial
    begin
        int on_len;
        int off_len;
        rsp.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold)
            begin
                rsp.ready <= 1'b0;
                repeat (RX_HOLD_LEN) @(posedge clk);
                rx_hold = 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                on_len = $urandom_range(1, 8);
                repeat (on_len) @(posedge clk);
                off_len = pick_gap();
                if (off_len > 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (off_len) @(posedge clk);
                end
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (due_results.size() == 0)
            begin
                // A result with nothing owed is reported against a zero key.
                report_mismatch("unexpected item, key_out", rsp.key_out, 0);
            end
            else
            begin
                want = due_results.pop_front();
                if (rsp.key_out !== want.key)
                    report_mismatch("key_out", rsp.key_out, want.key);
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.count !== want.count)
                    report_mismatch("count", rsp.count, want.count);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        int i;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.kind       = KIND_PUSH;
        req.key_in     = '0;
        heap_fill      = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        rx_hold        = 1'b0;
        steady         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (i = 0; i < N_DIRECTED; i++)
        begin
            send_op(directed_ops[i]);
            tx_pause();
        end

        // Mixed traffic at a moderate fill level.
        for (i = 0; i < 150; i++)
        begin
            send_op(mixed_op(heap_fill < 20 ? 60 : 40));
            tx_pause();
        end

        // Fill to capacity with the receiver held off at first, then push into a full heap.
        rx_hold = 1'b1;
        while (heap_fill < HEAP_CAP)
        begin
            send_op(plain_op(KIND_PUSH, rand_key()));
            tx_pause();
        end
        for (i = 0; i < 4; i++)
        begin
            send_op(plain_op(KIND_PUSH, rand_key()));
            tx_pause();
        end
        send_op(plain_op(KIND_PEEK, '0));

        // Sender pauses until every owed result has come back.
        req.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        @(posedge clk);

        // Drain to empty, with peeks mixed in, then touch the empty heap.
        while (heap_fill > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                send_op(plain_op(KIND_PEEK, rand_key()));
            else
                send_op(plain_op(KIND_POP, rand_key()));
            tx_pause();
        end
        for (i = 0; i < 3; i++)
        begin
            send_op(plain_op(KIND_POP, rand_key()));
            tx_pause();
        end
        send_op(plain_op(KIND_PEEK, rand_key()));
        tx_pause();

        // Back-to-back stretch, then random idling again.
        steady = 1'b1;
        for (i = 0; i < 60; i++)
        begin
            send_op(mixed_op(55));
            tx_pause();
        end
        steady = 1'b0;
        for (i = 0; i < 60; i++)
        begin
            send_op(mixed_op(45));
            tx_pause();
        end

        // Let the block finish and check that nothing is left over.
        req.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ min_heap_priority_queue.f @@
design/mhpq_pkg.sv
design/mhpq_if.sv
design/mhpq_ram.sv
design/mhpq_seq.sv
design/mhpq_out.sv
design/min_heap_priority_queue.sv
verif/tb_min_heap_priority_queue.sv
